### hdl/algd_pkg.sv
package algd_pkg;

  // Graph store dimensions
  localparam int MAX_VERTICES = 16;
  localparam int MAX_EDGES    = 256;

  // Operation codes carried by the kind field
  localparam logic [2:0] KIND_INSERT   = 3'd0;
  localparam logic [2:0] KIND_DELETE   = 3'd1;
  localparam logic [2:0] KIND_EXIST    = 3'd2;
  localparam logic [2:0] KIND_TRAVERSE = 3'd3;
  localparam logic [2:0] KIND_CLEAR    = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BAD    = 3'd1;
  localparam logic [2:0] ST_DUP    = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_ABSENT = 3'd4;

  localparam logic [4:0] VC_RESET = 5'd16;

  // Source of the list head read address
  typedef enum logic [1:0] {
    HS_U,
    HS_ROOT,
    HS_TGT
  } hsel_e;

  typedef struct packed {
    logic       in_load;
    logic       head_rd;
    hsel_e      head_sel;
    logic       edge_rd_p;
    logic       edge_rd_free;
    logic       walk_start;
    logic       walk_step;
    logic       ins_commit;
    logic       del_link;
    logic       del_free;
    logic       clr;
    logic       trav_init;
    logic       root_inc;
    logic       visit;
    logic       pop;
    logic       pop_load;
    logic       edge_step;
    logic       out_load;
    logic [2:0] out_status;
    logic       out_found;
    logic       out_visit;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       bad;
    logic       u_out;
    logic       p_null;
    logic       match;
    logic       fh_null;
    logic       root_vis;
    logic       tgt_ok;
    logic       sp_one;
    logic       last_visit;
    logic       out_free;
  } sts_t;

endpackage

### hdl/algd_ctrl.sv
module algd_ctrl import algd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_F_HEAD,
    S_F_CHK,
    S_F_EDGE,
    S_I_COMMIT,
    S_D_FREE,
    S_EMIT,
    S_T_ROOT,
    S_T_VISIT,
    S_T_LINK,
    S_T_POP,
    S_T_EDGE
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] code_q, code_d;
  logic       found_q, found_d;

  // Sequence one request through lookup, update and result, or through a depth-first traversal
  always_comb begin
    state_d    = state_q;
    code_d     = code_q;
    found_d    = found_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        code_d  = ST_OK;
        found_d = 1'b0;
        case (sts_i.kind)
          KIND_INSERT, KIND_DELETE: begin
            if (sts_i.bad) begin
              code_d  = ST_BAD;
              state_d = S_EMIT;
            end else begin
              cmd_o.head_rd  = 1'b1;
              cmd_o.head_sel = HS_U;
              state_d        = S_F_HEAD;
            end
          end
          KIND_EXIST: begin
            if (sts_i.u_out) begin
              state_d = S_EMIT;
            end else begin
              cmd_o.head_rd  = 1'b1;
              cmd_o.head_sel = HS_U;
              state_d        = S_F_HEAD;
            end
          end
          KIND_TRAVERSE: begin
            cmd_o.trav_init = 1'b1;
            state_d         = S_T_ROOT;
          end
          KIND_CLEAR: begin
            cmd_o.clr = 1'b1;
            state_d   = S_EMIT;
          end
          default: begin
            code_d  = ST_BAD;
            state_d = S_EMIT;
          end
        endcase
      end
      S_F_HEAD: begin
        cmd_o.walk_start = 1'b1;
        state_d          = S_F_CHK;
      end
      S_F_CHK: begin
        if (sts_i.p_null) begin
          // End of list: the edge is absent
          case (sts_i.kind)
            KIND_INSERT: begin
              if (sts_i.fh_null) begin
                code_d  = ST_FULL;
                state_d = S_EMIT;
              end else begin
                cmd_o.edge_rd_free = 1'b1;
                state_d            = S_I_COMMIT;
              end
            end
            KIND_DELETE: begin
              code_d  = ST_ABSENT;
              state_d = S_EMIT;
            end
            default: state_d = S_EMIT;
          endcase
        end else begin
          cmd_o.edge_rd_p = 1'b1;
          state_d         = S_F_EDGE;
        end
      end
      S_F_EDGE: begin
        if (sts_i.match) begin
          case (sts_i.kind)
            KIND_INSERT: begin
              code_d  = ST_DUP;
              state_d = S_EMIT;
            end
            KIND_DELETE: begin
              cmd_o.del_link = 1'b1;
              state_d        = S_D_FREE;
            end
            default: begin
              found_d = 1'b1;
              state_d = S_EMIT;
            end
          endcase
        end else begin
          cmd_o.walk_step = 1'b1;
          state_d         = S_F_CHK;
        end
      end
      S_I_COMMIT: begin
        cmd_o.ins_commit = 1'b1;
        state_d          = S_EMIT;
      end
      S_D_FREE: begin
        cmd_o.del_free = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = code_q;
          cmd_o.out_found  = found_q;
          cmd_o.out_last   = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_T_ROOT: begin
        if (sts_i.root_vis) begin
          cmd_o.root_inc = 1'b1;
        end else begin
          cmd_o.head_rd  = 1'b1;
          cmd_o.head_sel = HS_ROOT;
          state_d        = S_T_VISIT;
        end
      end
      S_T_VISIT: begin
        if (sts_i.out_free) begin
          cmd_o.visit      = 1'b1;
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = ST_OK;
          cmd_o.out_visit  = 1'b1;
          cmd_o.out_last   = sts_i.last_visit;
          state_d          = sts_i.last_visit ? S_IDLE : S_T_LINK;
        end
      end
      S_T_LINK: begin
        if (sts_i.p_null) begin
          cmd_o.pop = 1'b1;
          state_d   = sts_i.sp_one ? S_T_ROOT : S_T_POP;
        end else begin
          cmd_o.edge_rd_p = 1'b1;
          state_d         = S_T_EDGE;
        end
      end
      S_T_POP: begin
        cmd_o.pop_load = 1'b1;
        state_d        = S_T_LINK;
      end
      S_T_EDGE: begin
        cmd_o.edge_step = 1'b1;
        if (sts_i.tgt_ok) begin
          cmd_o.head_rd  = 1'b1;
          cmd_o.head_sel = HS_TGT;
          state_d        = S_T_VISIT;
        end else begin
          state_d = S_T_LINK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and result code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_OK;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
      found_q <= found_d;
    end
  end

endmodule

### hdl/algd_dpath.sv
module algd_dpath import algd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [4:0]         cfg_vertex_count_i,
  input  logic [2:0]         kind_i,
  input  logic [3:0]         src_vertex_i,
  input  logic [3:0]         dst_vertex_i,
  input  logic signed [15:0] edge_weight_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [2:0]         status_o,
  output logic               found_o,
  output logic [3:0]         visit_vertex_o,
  output logic [8:0]         edge_total_o,
  output logic               last_o,
  input  cmd_t               cmd_i,
  output sts_t               sts_o
);

  localparam int HAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int VW  = (HAW > 4) ? HAW : 4;
  localparam int NW  = VW + 1;
  localparam int SPW = $clog2(MAX_VERTICES + 1);
  localparam int LW  = $clog2(MAX_EDGES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam logic [LW-1:0] NIL = LW'(MAX_EDGES);

  // Configuration and effective vertex count
  logic [4:0]    vc_q;
  logic [NW-1:0] vcx, n_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= VC_RESET;
    end else if (cfg_valid_i) begin
      vc_q <= cfg_vertex_count_i;
    end
  end

  always_comb begin
    vcx = NW'(vc_q);
    if (vcx == '0) n_w = NW'(1);
    else if (vcx > NW'(MAX_VERTICES)) n_w = NW'(MAX_VERTICES);
    else n_w = vcx;
  end

  // Latched request
  logic [2:0]  kind_q;
  logic [3:0]  u_q, v_q;
  logic [15:0] w_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      kind_q <= kind_i;
      u_q    <= src_vertex_i;
      v_q    <= dst_vertex_i;
      w_q    <= edge_weight_i;
    end
  end

  logic [VW-1:0] ux;
  assign ux = VW'(u_q);

  // Pool bookkeeping
  logic [LW-1:0]  free_head_q, hw_q, cnt_q;
  logic [LW-1:0]  p_q, q_q, hd_q;
  logic [VW-1:0]  root_q, vtx_q;
  logic [MAX_VERTICES-1:0] vis_q;
  logic [SPW-1:0] sp_q, vcnt_q;

  // List heads: memory with a valid bit per vertex
  logic [LW-1:0]           head_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] head_vld_q;
  logic [LW-1:0]           head_rd_q;
  logic                    head_rv_q;
  logic [LW-1:0]           head_val;
  logic [VW-1:0]           ha;
  logic                    head_we;
  logic [LW-1:0]           head_wd;

  // Edge pool memories
  logic [3:0]     tgt_mem [MAX_EDGES];
  logic [15:0]    wgt_mem [MAX_EDGES];
  logic [LW-1:0]  nxt_mem [MAX_EDGES];
  logic [3:0]     tgt_rd_q;
  logic [LW-1:0]  nxt_rd_q, ea_q, nx;
  logic           fresh_q;
  logic           edge_rd;
  logic [LW-1:0]  ea;
  logic           nxt_we;
  logic [LW-1:0]  nxt_wa, nxt_wd;

  // Walk stack
  logic [LW-1:0]  stk_mem [MAX_VERTICES];
  logic [LW-1:0]  stk_rd_q;
  logic [SPW-1:0] spm1, spm2;
  logic [VW-1:0]  tx;

  assign spm1 = sp_q - SPW'(1);
  assign spm2 = sp_q - SPW'(2);
  assign tx   = VW'(tgt_rd_q);

  // Head read address and write port
  always_comb begin
    case (cmd_i.head_sel)
      HS_U:    ha = ux;
      HS_ROOT: ha = root_q;
      HS_TGT:  ha = tx;
      default: ha = ux;
    endcase
  end

  assign head_val = head_rv_q ? head_rd_q : NIL;
  assign head_we  = cmd_i.ins_commit || (cmd_i.del_link && (q_q == NIL));
  assign head_wd  = cmd_i.ins_commit ? free_head_q : nx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.head_rd) begin
      head_rd_q <= head_mem[ha[HAW-1:0]];
      head_rv_q <= head_vld_q[ha[HAW-1:0]];
    end
    if (head_we) begin
      head_mem[ux[HAW-1:0]] <= head_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= '0;
    end else if (cmd_i.clr) begin
      head_vld_q <= '0;
    end else if (head_we) begin
      head_vld_q[ux[HAW-1:0]] <= 1'b1;
    end
  end

  // Edge read: slots at or above the watermark chain to the next slot
  assign edge_rd = cmd_i.edge_rd_p || cmd_i.edge_rd_free;
  assign ea      = cmd_i.edge_rd_free ? free_head_q : p_q;
  assign nx      = fresh_q ? (ea_q + LW'(1)) : nxt_rd_q;

  always_comb begin
    nxt_we = 1'b0;
    nxt_wa = q_q;
    nxt_wd = nx;
    if (cmd_i.ins_commit) begin
      nxt_we = 1'b1;
      nxt_wa = free_head_q;
      nxt_wd = hd_q;
    end else if (cmd_i.del_link && (q_q != NIL)) begin
      nxt_we = 1'b1;
    end else if (cmd_i.del_free) begin
      nxt_we = 1'b1;
      nxt_wa = p_q;
      nxt_wd = free_head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_rd) begin
      tgt_rd_q <= tgt_mem[ea[EAW-1:0]];
      nxt_rd_q <= nxt_mem[ea[EAW-1:0]];
      ea_q     <= ea;
      fresh_q  <= (ea >= hw_q);
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa[EAW-1:0]] <= nxt_wd;
    end
    if (cmd_i.ins_commit) begin
      tgt_mem[free_head_q[EAW-1:0]] <= v_q;
      wgt_mem[free_head_q[EAW-1:0]] <= w_q;
    end
  end

  // Stack write and read
  always_ff @(posedge clk_i) begin
    if (cmd_i.visit) begin
      stk_mem[sp_q[HAW-1:0]] <= head_val;
    end else if (cmd_i.edge_step) begin
      stk_mem[spm1[HAW-1:0]] <= nx;
    end
    if (cmd_i.pop) begin
      stk_rd_q <= stk_mem[spm2[HAW-1:0]];
    end
  end

  // Walk pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start) begin
      p_q  <= head_val;
      hd_q <= head_val;
      q_q  <= NIL;
    end else if (cmd_i.walk_step) begin
      q_q <= p_q;
      p_q <= nx;
    end else if (cmd_i.visit) begin
      p_q <= head_val;
    end else if (cmd_i.pop_load) begin
      p_q <= stk_rd_q;
    end else if (cmd_i.edge_step) begin
      p_q <= nx;
    end
    if (cmd_i.head_rd) begin
      vtx_q <= (cmd_i.head_sel == HS_TGT) ? tx : root_q;
    end
  end

  // Free list, watermark, edge count and traversal control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      hw_q        <= '0;
      cnt_q       <= '0;
      root_q      <= '0;
      vis_q       <= '0;
      sp_q        <= '0;
      vcnt_q      <= '0;
    end else begin
      if (cmd_i.clr) begin
        free_head_q <= '0;
        hw_q        <= '0;
        cnt_q       <= '0;
        vis_q       <= '0;
      end else if (cmd_i.ins_commit) begin
        free_head_q <= nx;
        cnt_q       <= cnt_q + LW'(1);
        if (free_head_q == hw_q) hw_q <= hw_q + LW'(1);
      end else if (cmd_i.del_free) begin
        free_head_q <= p_q;
        if (cnt_q != '0) cnt_q <= cnt_q - LW'(1);
      end
      if (cmd_i.trav_init) begin
        vis_q  <= '0;
        root_q <= '0;
        sp_q   <= '0;
        vcnt_q <= '0;
      end else begin
        if (cmd_i.root_inc) root_q <= root_q + VW'(1);
        if (cmd_i.visit) begin
          vis_q[vtx_q[HAW-1:0]] <= 1'b1;
          sp_q                  <= sp_q + SPW'(1);
          vcnt_q                <= vcnt_q + SPW'(1);
        end else if (cmd_i.pop) begin
          sp_q <= spm1;
        end
      end
    end
  end

  // Result register
  logic [LW+8:0] tot_ext;
  assign tot_ext = {9'd0, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o       <= cmd_i.out_status;
      found_o        <= cmd_i.out_found;
      visit_vertex_o <= cmd_i.out_visit ? vtx_q[3:0] : 4'd0;
      edge_total_o   <= tot_ext[8:0];
      last_o         <= cmd_i.out_last;
    end
  end

  // Status towards the controller
  always_comb begin
    sts_o.kind       = kind_q;
    sts_o.u_out      = (NW'(u_q) >= n_w);
    sts_o.bad        = sts_o.u_out || (NW'(v_q) >= n_w) || (u_q == v_q);
    sts_o.p_null     = (p_q == NIL);
    sts_o.match      = (tgt_rd_q == v_q);
    sts_o.fh_null    = (free_head_q == NIL);
    sts_o.root_vis   = vis_q[root_q[HAW-1:0]];
    sts_o.tgt_ok     = (NW'(tgt_rd_q) < n_w) && !vis_q[tx[HAW-1:0]]
                       && (sp_q < SPW'(MAX_VERTICES));
    sts_o.sp_one     = (sp_q == SPW'(1));
    sts_o.last_visit = ((NW'(vcnt_q) + NW'(1)) == n_w);
    sts_o.out_free   = !out_valid_o || out_ready_i;
  end

endmodule

### hdl/adjacency_list_graph_dfs.sv
// Insert, delete and exist walk the source vertex list, comparing each stored edge in turn.
// Clear and rejected requests go straight to the result; traverse walks the n active vertices
// depth first over the E stored edges, reading one edge at a time.
// One request is in work at a time; a new request is taken once the result is registered.
// Reset is asynchronous, active low: empty graph, vertex count 16, no clearing pass.
module adjacency_list_graph_dfs import algd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [4:0]         cfg_vertex_count_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         kind_i,
  input  logic [3:0]         src_vertex_i,
  input  logic [3:0]         dst_vertex_i,
  input  logic signed [15:0] edge_weight_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic               found_o,
  output logic [3:0]         visit_vertex_o,
  output logic [8:0]         edge_total_o,
  output logic               last_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  algd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  algd_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_vertex_count_i (cfg_vertex_count_i),
    .kind_i             (kind_i),
    .src_vertex_i       (src_vertex_i),
    .dst_vertex_i       (dst_vertex_i),
    .edge_weight_i      (edge_weight_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .status_o           (status_o),
    .found_o            (found_o),
    .visit_vertex_o     (visit_vertex_o),
    .edge_total_o       (edge_total_o),
    .last_o             (last_o),
    .cmd_i              (cmd),
    .sts_o              (sts)
  );

endmodule

### hdl/algd_chk.sv
module algd_chk import algd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] status_o,
  input logic       found_o,
  input logic       last_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(last_o))
    else $error("result changed while stalled");

  // Drop ready once a request is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // Found only on a successful query
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == ST_OK && last_o)
    else $error("found set on a failed or traversal result");

  // Errors end their request
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> last_o)
    else $error("error result without last");

endmodule

bind adjacency_list_graph_dfs algd_chk u_algd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .found_o     (found_o),
  .last_o      (last_o)
);

### bench/graph_dfs_checker.sv
`timescale 1ns / 1ps

module graph_dfs_checker import algd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [4:0]         cfg_vertex_count_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         kind_i,
  input  logic [3:0]         src_vertex_i,
  input  logic [3:0]         dst_vertex_i,
  input  logic signed [15:0] edge_weight_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [2:0]         status_i,
  input  logic               found_i,
  input  logic [3:0]         visit_vertex_i,
  input  logic [8:0]         edge_total_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_seen_o,
  output int                 traverse_seen_o
);

  localparam int NV  = 16;
  localparam int NE  = 256;
  localparam int NIL = NE;

  typedef struct packed {
    logic [2:0] status;
    logic       found;
    logic [3:0] visit;
    logic [8:0] total;
    logic       last;
  } graph_result_t;

  // Shadow copy of the graph store
  logic [4:0]  vcount;
  int          head_of[NV];
  logic [3:0]  target_of[NE];
  logic [15:0] weight_of[NE];
  int          next_of[NE];
  int          free_slot;
  int          edges_held;
  graph_result_t result_q[$];

  function automatic int active_n();
    if (vcount == 0) return 1;
    if (vcount > NV) return NV;
    return int'(vcount);
  endfunction

  function automatic void wipe_graph();
    for (int i = 0; i < NV; i++) head_of[i] = NIL;
    for (int i = 0; i < NE; i++) next_of[i] = i + 1;
    free_slot  = 0;
    edges_held = 0;
  endfunction

  // Walk the list of u for target v; prev gets the slot before it
  function automatic int find_slot(int u, int v, output int prev);
    int p;
    p    = head_of[u];
    prev = NIL;
    while (p < NIL && int'(target_of[p]) != v) begin
      prev = p;
      p    = next_of[p];
    end
    return p;
  endfunction

  function automatic void push_one(logic [2:0] st, logic fnd);
    graph_result_t r;
    r = '{status: st, found: fnd, visit: 4'd0, total: edges_held[8:0], last: 1'b1};
    result_q.push_back(r);
  endfunction

  // Depth-first visit order with an explicit stack
  function automatic void predict_walk();
    int n, cnt, sp, p, t;
    logic [NV-1:0] seen;
    int order[NV];
    int stk_link[NV];
    graph_result_t r;
    n = active_n();
    cnt = 0;
    seen = '0;
    for (int root = 0; root < n; root++) begin
      if (!seen[root]) begin
        seen[root] = 1'b1;
        order[cnt++] = root;
        stk_link[0] = head_of[root];
        sp = 1;
        while (sp > 0) begin
          p = stk_link[sp-1];
          if (p >= NIL) begin
            sp--;
          end else begin
            t = int'(target_of[p]);
            stk_link[sp-1] = next_of[p];
            if (t < n && !seen[t] && sp < NV) begin
              seen[t] = 1'b1;
              order[cnt++] = t;
              stk_link[sp] = head_of[t];
              sp++;
            end
          end
        end
      end
    end
    for (int i = 0; i < cnt; i++) begin
      r = '{status: ST_OK, found: 1'b0, visit: order[i][3:0], total: edges_held[8:0],
            last: (i + 1 == cnt)};
      result_q.push_back(r);
    end
  endfunction

  function automatic void predict_request(logic [2:0] kind, int u, int v, logic [15:0] w);
    int n, p, q;
    logic bad;
    n   = active_n();
    bad = (u >= n) || (v >= n) || (u == v);
    case (kind)
      KIND_INSERT: begin
        if (bad) push_one(ST_BAD, 1'b0);
        else if (find_slot(u, v, q) < NIL) push_one(ST_DUP, 1'b0);
        else if (free_slot >= NIL) push_one(ST_FULL, 1'b0);
        else begin
          p = free_slot;
          free_slot = next_of[p];
          target_of[p] = v[3:0];
          weight_of[p] = w;
          next_of[p] = head_of[u];
          head_of[u] = p;
          edges_held++;
          push_one(ST_OK, 1'b0);
        end
      end
      KIND_DELETE: begin
        if (bad) push_one(ST_BAD, 1'b0);
        else begin
          p = find_slot(u, v, q);
          if (p >= NIL) push_one(ST_ABSENT, 1'b0);
          else begin
            if (q < NIL) next_of[q] = next_of[p];
            else head_of[u] = next_of[p];
            next_of[p] = free_slot;
            free_slot = p;
            if (edges_held > 0) edges_held--;
            push_one(ST_OK, 1'b0);
          end
        end
      end
      KIND_EXIST: begin
        if (u >= n) push_one(ST_OK, 1'b0);
        else push_one(ST_OK, find_slot(u, v, q) < NIL);
      end
      KIND_TRAVERSE: predict_walk();
      KIND_CLEAR: begin
        wipe_graph();
        push_one(ST_OK, 1'b0);
      end
      default: push_one(ST_BAD, 1'b0);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  // Track configuration and requests, compare each result with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    graph_result_t e;
    if (!rst_ni) begin
      vcount = VC_RESET;
      wipe_graph();
      result_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) vcount = cfg_vertex_count_i;
      if (in_valid_i && in_ready_i)
        predict_request(kind_i, int'(src_vertex_i), int'(dst_vertex_i), edge_weight_i);
      if (out_valid_i && out_ready_i) begin
        results_seen_o++;
        if (result_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          e = result_q.pop_front();
          if (e.visit != 0 || (e.status == ST_OK && !e.last)) traverse_seen_o++;
          if (status_i !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", status_i, e.status));
          if (found_i !== e.found)
            report_mismatch($sformatf("found %0b, want %0b", found_i, e.found));
          if (visit_vertex_i !== e.visit)
            report_mismatch($sformatf("visit %0d, want %0d", visit_vertex_i, e.visit));
          if (edge_total_i !== e.total)
            report_mismatch($sformatf("edge total %0d, want %0d", edge_total_i, e.total));
          if (last_i !== e.last)
            report_mismatch($sformatf("last %0b, want %0b", last_i, e.last));
        end
      end
    end
    pending_o = result_q.size();
  end

  initial begin
    fail_count_o    = 0;
    pending_o       = 0;
    results_seen_o  = 0;
    traverse_seen_o = 0;
  end

endmodule

### bench/tb_adjacency_list_graph_dfs.sv
`timescale 1ns / 1ps

module tb_adjacency_list_graph_dfs;
  import algd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_REQUESTS = 200;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [4:0]         cfg_vertex_count_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         kind_i;
  logic [3:0]         src_vertex_i;
  logic [3:0]         dst_vertex_i;
  logic signed [15:0] edge_weight_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [2:0]         status_o;
  logic               found_o;
  logic [3:0]         visit_vertex_o;
  logic [8:0]         edge_total_o;
  logic               last_o;

  int  fail_count, pending, results_seen, traverse_seen;
  int  idle_cycles;
  bit  rx_calm, rx_hold;
  int  active_vc;

  adjacency_list_graph_dfs i_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_vertex_count_i,
    .in_valid_i, .in_ready_o, .kind_i, .src_vertex_i, .dst_vertex_i, .edge_weight_i,
    .out_valid_o, .out_ready_i, .status_o, .found_o, .visit_vertex_o, .edge_total_o,
    .last_o
  );

  graph_dfs_checker i_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_vertex_count_i,
    .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .src_vertex_i, .dst_vertex_i,
    .edge_weight_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o), .found_i(found_o),
    .visit_vertex_i(visit_vertex_o), .edge_total_i(edge_total_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen),
    .traverse_seen_o(traverse_seen)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Receiver: random stalls, a calm stretch, and one long hold-off
  always @(posedge clk_i) begin
    if (rx_hold) out_ready_i <= 1'b0;
    else if (rx_calm) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(99) >= 10);
  end

  // Watchdog on cycles with no accepted handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || rx_hold) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one request, with an optional random gap before it; valid stays up for the next one
  task automatic send_request(input logic [2:0] kind, input logic [3:0] u,
                              input logic [3:0] v, input logic [15:0] w, input bit gaps);
    while (gaps && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    src_vertex_i <= u;
    dst_vertex_i <= v;
    edge_weight_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop sending, wait until every result is in, then let the block settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(input logic [4:0] vc);
    drain_results();
    cfg_valid_i        <= 1'b1;
    cfg_vertex_count_i <= vc;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    active_vc = (vc == 0) ? 1 : (vc > 16 ? 16 : vc);
  endtask

  // Mostly well-formed requests, with endpoints mostly within the active vertex range
  task automatic random_request(input bit gaps);
    logic [2:0] kind;
    logic [3:0] u, v;
    int sel;
    sel = $urandom_range(99);
    if (sel < 45) kind = KIND_INSERT;
    else if (sel < 65) kind = KIND_DELETE;
    else if (sel < 82) kind = KIND_EXIST;
    else if (sel < 93) kind = KIND_TRAVERSE;
    else if (sel < 95) kind = KIND_CLEAR;
    else kind = 3'($urandom_range(7));
    if ($urandom_range(9) == 0) begin
      u = 4'($urandom);
      v = 4'($urandom);
    end else begin
      u = 4'($urandom_range(active_vc - 1));
      v = 4'($urandom_range(active_vc - 1));
    end
    send_request(kind, u, v, 16'($urandom), gaps);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_vertex_count_i = '0;
    in_valid_i = 1'b0;
    kind_i = KIND_INSERT;
    src_vertex_i = '0;
    dst_vertex_i = '0;
    edge_weight_i = '0;
    out_ready_i = 1'b0;
    idle_cycles = 0;
    rx_calm = 1'b0;
    rx_hold = 1'b0;
    active_vc = 16;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every kind, duplicate, bad and absent cases
    send_request(KIND_TRAVERSE, 4'd0, 4'd0, 16'd0, 1'b0);
    send_request(KIND_INSERT, 4'd0, 4'd15, 16'h8000, 1'b0);
    send_request(KIND_INSERT, 4'd15, 4'd0, 16'h7fff, 1'b0);
    send_request(KIND_INSERT, 4'd0, 4'd15, 16'hffff, 1'b0);
    send_request(KIND_INSERT, 4'd7, 4'd7, 16'd1, 1'b0);
    send_request(KIND_INSERT, 4'd0, 4'd5, 16'd2, 1'b0);
    send_request(KIND_INSERT, 4'd5, 4'd10, 16'd3, 1'b0);
    send_request(KIND_EXIST, 4'd0, 4'd15, 16'd0, 1'b0);
    send_request(KIND_EXIST, 4'd15, 4'd1, 16'd0, 1'b0);
    send_request(KIND_DELETE, 4'd3, 4'd4, 16'd0, 1'b0);
    send_request(KIND_DELETE, 4'd2, 4'd2, 16'd0, 1'b0);
    send_request(KIND_TRAVERSE, 4'd0, 4'd0, 16'd0, 1'b0);
    send_request(KIND_DELETE, 4'd0, 4'd15, 16'd0, 1'b0);
    send_request(3'd5, 4'd1, 4'd2, 16'd0, 1'b0);
    send_request(3'd7, 4'd15, 4'd15, 16'hffff, 1'b0);
    // Shrink the vertex count: stale edges and out-of-range endpoints
    write_vertex_count(5'd6);
    send_request(KIND_TRAVERSE, 4'd0, 4'd0, 16'd0, 1'b0);
    send_request(KIND_EXIST, 4'd9, 4'd0, 16'd0, 1'b0);
    send_request(KIND_INSERT, 4'd1, 4'd6, 16'd0, 1'b0);
    write_vertex_count(5'd0);
    send_request(KIND_TRAVERSE, 4'd0, 4'd0, 16'd0, 1'b0);
    send_request(KIND_INSERT, 4'd0, 4'd1, 16'd0, 1'b0);
    write_vertex_count(5'd31);
    send_request(KIND_TRAVERSE, 4'd0, 4'd0, 16'd0, 1'b0);
    send_request(KIND_CLEAR, 4'd0, 4'd0, 16'd0, 1'b0);

    // Random phases across several vertex counts
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_vertex_count(5'd16);
        1: write_vertex_count(5'd1);
        2: write_vertex_count(5'd4);
        3: write_vertex_count(5'($urandom_range(2, 31)));
        default: write_vertex_count(5'd8);
      endcase
      if (phase == 2) rx_calm = 1'b1;
      for (int i = 0; i < RANDOM_REQUESTS / 5; i++) random_request(phase != 2);
      rx_calm = 1'b0;
      // Hold the receiver off while requests keep coming
      if (phase == 0) begin
        fork
          begin
            rx_hold = 1'b1;
            repeat (300) @(posedge clk_i);
            rx_hold = 1'b0;
          end
          begin
            for (int i = 0; i < 4; i++) random_request(1'b0);
            in_valid_i <= 1'b0;
          end
        join
      end
    end

    // Build long source lists on a wide graph
    write_vertex_count(5'd16);
    send_request(KIND_CLEAR, 4'd0, 4'd0, 16'd0, 1'b0);
    for (int a = 0; a < 4; a++)
      for (int b = 0; b < 16; b++)
        if (a != b) send_request(KIND_INSERT, 4'(a), 4'(b), 16'($urandom), 1'b0);
    for (int i = 0; i < 20; i++) send_request(KIND_DELETE, 4'(i % 16), 4'((i + 3) % 16),
                                              16'd0, 1'b0);
    for (int i = 0; i < 24; i++) random_request(1'b1);
    send_request(KIND_TRAVERSE, 4'd0, 4'd0, 16'd0, 1'b0);

    drain_results();
    $display("covered %0d results, %0d traversal entries, vertex counts from 0 to 31",
             results_seen, traverse_seen);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### adjacency_list_graph_dfs.f
hdl/algd_pkg.sv
hdl/algd_ctrl.sv
hdl/algd_dpath.sv
hdl/adjacency_list_graph_dfs.sv
hdl/algd_chk.sv
bench/graph_dfs_checker.sv
bench/tb_adjacency_list_graph_dfs.sv
